// ===== rtl/sgt_pkg.sv =====
package sgt_pkg;

    localparam int CLAP_WINDOW_DEF  = 5;
    localparam int RAISE_WINDOW_DEF = 60;

    localparam int POS_W  = 15;   // joint coordinate width
    localparam int DIFF_W = 16;   // coordinate difference width
    localparam int SQ_W   = 32;   // squared distance width
    localparam int ROOT_W = 16;   // distance width
    localparam int LVL_W  = 16;   // configuration register width
    localparam int ROOT_STEPS = 16;
    localparam int SQ_STEPS   = 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CLAP_CLOSE  = 2'd0,
        REG_CLAP_OPEN   = 2'd1,
        REG_RAISE_FIRE  = 2'd2,
        REG_RAISE_REARM = 2'd3
    } reg_index_t;

    // detector codes on the source field
    localparam logic [1:0] SRC_CLAP  = 2'd0;
    localparam logic [1:0] SRC_RIGHT = 2'd1;
    localparam logic [1:0] SRC_LEFT  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       sq_mul;
        logic [1:0] sq_sel;
        logic       sq_acc;
        logic       root_step;
        logic       commit;
    } dp_cmd_t;

endpackage

// ===== rtl/sgt_ram.sv =====
module sgt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 60,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sgt_ctrl.sv =====
module sgt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sgt_pkg::dp_cmd_t cmd
);
    import sgt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQ   = 4'b0010,
        S_ROOT = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign free      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sq_sel = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_mul = (cnt_reg < 4'(SQ_STEPS));
                cmd.sq_acc = (cnt_reg != '0);
                cnt_next   = cnt_reg + 4'd1;
                if (cnt_reg == 4'(SQ_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'(ROOT_STEPS - 1))
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // one frame at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("frame accepted while another is in flight");

    // a committed result is offered next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    // root iterations never overlap squaring
    a_root_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_step |-> !(cmd.sq_mul || cmd.sq_acc || cmd.commit))
        else $error("root step overlaps other work");

endmodule

// ===== rtl/sgt_datapath.sv =====
module sgt_datapath #(
    parameter int CLAP_WINDOW  = sgt_pkg::CLAP_WINDOW_DEF,
    parameter int RAISE_WINDOW = sgt_pkg::RAISE_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sgt_pkg::dp_cmd_t                    cmd,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [sgt_pkg::LVL_W-1:0]           cfg_data,
    input  logic [3:0]                          confident_mask,
    input  logic signed [sgt_pkg::POS_W-1:0]    right_hand_x,
    input  logic signed [sgt_pkg::POS_W-1:0]    right_hand_y,
    input  logic signed [sgt_pkg::POS_W-1:0]    right_hand_z,
    input  logic signed [sgt_pkg::POS_W-1:0]    left_hand_x,
    input  logic signed [sgt_pkg::POS_W-1:0]    left_hand_y,
    input  logic signed [sgt_pkg::POS_W-1:0]    left_hand_z,
    input  logic signed [sgt_pkg::POS_W-1:0]    right_shoulder_y,
    input  logic signed [sgt_pkg::POS_W-1:0]    left_shoulder_y,
    output logic                                fired,
    output logic [1:0]                          source,
    output logic signed [sgt_pkg::POS_W-1:0]    event_x,
    output logic signed [sgt_pkg::POS_W-1:0]    event_y,
    output logic signed [sgt_pkg::POS_W-1:0]    event_z
);
    import sgt_pkg::*;

    localparam int CFW = $clog2(CLAP_WINDOW + 1);
    localparam int RFW = $clog2(RAISE_WINDOW + 1);
    localparam int RAW = (RAISE_WINDOW > 1) ? $clog2(RAISE_WINDOW) : 1;
    localparam int CSW = ROOT_W + CFW;
    localparam int RSW = DIFF_W + 1 + RFW;
    localparam logic [CSW-1:0]        CW_K = CSW'(CLAP_WINDOW);
    localparam logic signed [RSW-1:0] RW_K = RSW'(RAISE_WINDOW);
    localparam logic [RAW-1:0]        RAISE_LAST = RAW'(RAISE_WINDOW - 1);

    // configuration registers
    logic [LVL_W-1:0]        clap_close_reg, clap_open_reg;
    logic signed [LVL_W-1:0] raise_fire_reg, raise_rearm_reg;

    // latched frame
    logic [3:0]              mask_reg;
    logic signed [POS_W-1:0] rx_reg, ry_reg, rz_reg, lx_reg, ly_reg, lz_reg;
    logic signed [POS_W-1:0] rsy_reg, lsy_reg;

    // squaring and root
    logic signed [DIFF_W-1:0] dx, dy, dz, dsel;
    logic signed [SQ_W-1:0]   sq_full;
    logic [SQ_W-1:0]          prod_reg, acc_reg;
    logic [ROOT_W+2:0]        rem_reg, rem_shift, trial;
    logic [ROOT_W-1:0]        root_reg;

    // detector state
    logic [ROOT_W-1:0]        clap_win_reg [CLAP_WINDOW];
    logic [CSW-1:0]           clap_sum_reg;
    logic [CFW-1:0]           clap_fill_reg;
    logic                     clap_armed_reg;
    logic signed [RSW-1:0]    rr_sum_reg, lr_sum_reg;
    logic [RFW-1:0]           rr_fill_reg, lr_fill_reg;
    logic                     rr_armed_reg, lr_armed_reg;
    logic [RAW-1:0]           rr_ptr_reg, lr_ptr_reg;
    logic [DIFF_W-1:0]        rr_old, lr_old;

    assign dx = DIFF_W'(rx_reg) - DIFF_W'(lx_reg);
    assign dy = DIFF_W'(ry_reg) - DIFF_W'(ly_reg);
    assign dz = DIFF_W'(rz_reg) - DIFF_W'(lz_reg);

    always_comb
    begin
        case (cmd.sq_sel)
            2'd0:    dsel = dx;
            2'd1:    dsel = dy;
            default: dsel = dz;
        endcase
    end

    assign sq_full   = SQ_W'(dsel) * SQ_W'(dsel);
    assign rem_shift = {rem_reg[ROOT_W:0], acc_reg[SQ_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clap_close_reg  <= LVL_W'(140);
            clap_open_reg   <= LVL_W'(300);
            raise_fire_reg  <= LVL_W'(10);
            raise_rearm_reg <= -LVL_W'(20);
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CLAP_CLOSE:  clap_close_reg  <= cfg_data;
                REG_CLAP_OPEN:   clap_open_reg   <= cfg_data;
                REG_RAISE_FIRE:  raise_fire_reg  <= cfg_data;
                REG_RAISE_REARM: raise_rearm_reg <= cfg_data;
                default:         clap_close_reg  <= clap_close_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg <= confident_mask;
            rx_reg   <= right_hand_x;
            ry_reg   <= right_hand_y;
            rz_reg   <= right_hand_z;
            lx_reg   <= left_hand_x;
            ly_reg   <= left_hand_y;
            lz_reg   <= left_hand_z;
            rsy_reg  <= right_shoulder_y;
            lsy_reg  <= left_shoulder_y;
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            if (cmd.sq_mul)
            begin
                prod_reg <= $unsigned(sq_full);
            end
            if (cmd.sq_acc)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            if (cmd.root_step)
            begin
                acc_reg <= acc_reg << 2;
                if (rem_shift >= trial)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // clap detector
    logic               clap_en, clap_full, clap_fire, clap_rearm;
    logic [CSW-1:0]     clap_sum_next, close_thr, open_thr;

    assign clap_en   = (mask_reg[1:0] == 2'b11);
    assign clap_full = (clap_fill_reg == CFW'(CLAP_WINDOW));
    assign close_thr = CSW'(clap_close_reg) * CW_K;
    assign open_thr  = CSW'(clap_open_reg) * CW_K;
    assign clap_sum_next = clap_sum_reg + CSW'(root_reg)
                         - (clap_full ? CSW'(clap_win_reg[CLAP_WINDOW-1]) : CSW'(0));
    assign clap_fire  = clap_full && clap_armed_reg && (clap_sum_next < close_thr);
    assign clap_rearm = clap_full && (clap_sum_next > open_thr);

    // raise detectors share the thresholds
    logic signed [DIFF_W-1:0] rr_smp, lr_smp;
    logic signed [RSW-1:0]    fire_thr, rearm_thr, rr_sum_next, lr_sum_next;
    logic                     rr_en, lr_en, rr_full, lr_full;
    logic                     rr_fire, rr_rearm, lr_fire, lr_rearm;

    assign rr_smp    = DIFF_W'(ry_reg) - DIFF_W'(rsy_reg);
    assign lr_smp    = DIFF_W'(ly_reg) - DIFF_W'(lsy_reg);
    assign fire_thr  = RSW'(raise_fire_reg) * RW_K;
    assign rearm_thr = RSW'(raise_rearm_reg) * RW_K;
    assign rr_en     = (mask_reg[2] && mask_reg[0]);
    assign lr_en     = (mask_reg[3] && mask_reg[1]);
    assign rr_full   = (rr_fill_reg == RFW'(RAISE_WINDOW));
    assign lr_full   = (lr_fill_reg == RFW'(RAISE_WINDOW));
    assign rr_sum_next = rr_sum_reg + RSW'(rr_smp)
                       - (rr_full ? RSW'($signed(rr_old)) : RSW'(0));
    assign lr_sum_next = lr_sum_reg + RSW'(lr_smp)
                       - (lr_full ? RSW'($signed(lr_old)) : RSW'(0));
    assign rr_fire  = rr_full && rr_armed_reg && (rr_sum_next > fire_thr);
    assign rr_rearm = rr_full && (rr_sum_next < rearm_thr);
    assign lr_fire  = lr_full && lr_armed_reg && (lr_sum_next > fire_thr);
    assign lr_rearm = lr_full && (lr_sum_next < rearm_thr);

    sgt_ram #(.WIDTH(DIFF_W), .DEPTH(RAISE_WINDOW), .AW(RAW)) u_rr_ram (
        .clk   (clk),
        .we    (cmd.commit && rr_en),
        .waddr (rr_ptr_reg),
        .wdata (rr_smp),
        .raddr (rr_ptr_reg),
        .rdata (rr_old)
    );

    sgt_ram #(.WIDTH(DIFF_W), .DEPTH(RAISE_WINDOW), .AW(RAW)) u_lr_ram (
        .clk   (clk),
        .we    (cmd.commit && lr_en),
        .waddr (lr_ptr_reg),
        .wdata (lr_smp),
        .raddr (lr_ptr_reg),
        .rdata (lr_old)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clap_sum_reg   <= '0;
            clap_fill_reg  <= '0;
            clap_armed_reg <= 1'b0;
            rr_sum_reg     <= '0;
            rr_fill_reg    <= '0;
            rr_armed_reg   <= 1'b0;
            rr_ptr_reg     <= '0;
            lr_sum_reg     <= '0;
            lr_fill_reg    <= '0;
            lr_armed_reg   <= 1'b0;
            lr_ptr_reg     <= '0;
            for (int i = 0; i < CLAP_WINDOW; i++)
            begin
                clap_win_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (clap_en)
            begin
                clap_sum_reg    <= clap_sum_next;
                clap_win_reg[0] <= root_reg;
                for (int i = 1; i < CLAP_WINDOW; i++)
                begin
                    clap_win_reg[i] <= clap_win_reg[i-1];
                end
                if (!clap_full)
                begin
                    clap_fill_reg <= clap_fill_reg + CFW'(1);
                end
                if (clap_rearm)
                begin
                    clap_armed_reg <= 1'b1;
                end
                else if (clap_fire)
                begin
                    clap_armed_reg <= 1'b0;
                end
            end
            if (rr_en)
            begin
                rr_sum_reg <= rr_sum_next;
                rr_ptr_reg <= (rr_ptr_reg == RAISE_LAST) ? '0 : rr_ptr_reg + RAW'(1);
                if (!rr_full)
                begin
                    rr_fill_reg <= rr_fill_reg + RFW'(1);
                end
                if (rr_rearm)
                begin
                    rr_armed_reg <= 1'b1;
                end
                else if (rr_fire)
                begin
                    rr_armed_reg <= 1'b0;
                end
            end
            if (lr_en)
            begin
                lr_sum_reg <= lr_sum_next;
                lr_ptr_reg <= (lr_ptr_reg == RAISE_LAST) ? '0 : lr_ptr_reg + RAW'(1);
                if (!lr_full)
                begin
                    lr_fill_reg <= lr_fill_reg + RFW'(1);
                end
                if (lr_rearm)
                begin
                    lr_armed_reg <= 1'b1;
                end
                else if (lr_fire)
                begin
                    lr_armed_reg <= 1'b0;
                end
            end
        end
    end

    // result register; left raise wins over right raise, which wins over clap
    logic signed [DIFF_W-1:0] sx, sy, sz;

    assign sx = DIFF_W'(rx_reg) + DIFF_W'(lx_reg);
    assign sy = DIFF_W'(ry_reg) + DIFF_W'(ly_reg);
    assign sz = DIFF_W'(rz_reg) + DIFF_W'(lz_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            fired   <= 1'b0;
            source  <= SRC_CLAP;
            event_x <= '0;
            event_y <= '0;
            event_z <= '0;
            if (lr_en && lr_fire)
            begin
                fired   <= 1'b1;
                source  <= SRC_LEFT;
                event_x <= lx_reg;
                event_y <= ly_reg;
                event_z <= lz_reg;
            end
            else if (rr_en && rr_fire)
            begin
                fired   <= 1'b1;
                source  <= SRC_RIGHT;
                event_x <= rx_reg;
                event_y <= ry_reg;
                event_z <= rz_reg;
            end
            else if (clap_en && clap_fire)
            begin
                fired   <= 1'b1;
                source  <= SRC_CLAP;
                event_x <= POS_W'(sx >>> 1);
                event_y <= POS_W'(sy >>> 1);
                event_z <= POS_W'(sz >>> 1);
            end
        end
    end

    // fill counts never pass the window length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rr_fill_reg <= RFW'(RAISE_WINDOW)) && (lr_fill_reg <= RFW'(RAISE_WINDOW))
        && (clap_fill_reg <= CFW'(CLAP_WINDOW)))
        else $error("window fill count overrun");

endmodule

// ===== rtl/skeleton_gesture_triggers_unit.sv =====
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   confident_mask, hand and shoulder positions
// out       output     out_valid / out_ready fired, source, event_x/y/z
// cfg       input      cfg_we                cfg_index, cfg_data (no back-pressure)
//
// each frame passes through the accept state, the shared squarer, the bit-serial square
// root and the update state, in which the result is committed
// a new frame can be accepted the cycle after the previous result is committed
// a stalled output holds the update cycle until the result register is free
// reset clears control, sums, fill counts and trigger state; the raise windows need no
// clearing as an entry is read only once written
module skeleton_gesture_triggers_unit #(
    parameter int CLAP_WINDOW  = sgt_pkg::CLAP_WINDOW_DEF,
    parameter int RAISE_WINDOW = sgt_pkg::RAISE_WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [3:0]                       confident_mask,
    input  logic signed [sgt_pkg::POS_W-1:0] right_hand_x,
    input  logic signed [sgt_pkg::POS_W-1:0] right_hand_y,
    input  logic signed [sgt_pkg::POS_W-1:0] right_hand_z,
    input  logic signed [sgt_pkg::POS_W-1:0] left_hand_x,
    input  logic signed [sgt_pkg::POS_W-1:0] left_hand_y,
    input  logic signed [sgt_pkg::POS_W-1:0] left_hand_z,
    input  logic signed [sgt_pkg::POS_W-1:0] right_shoulder_y,
    input  logic signed [sgt_pkg::POS_W-1:0] left_shoulder_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             fired,
    output logic [1:0]                       source,
    output logic signed [sgt_pkg::POS_W-1:0] event_x,
    output logic signed [sgt_pkg::POS_W-1:0] event_y,
    output logic signed [sgt_pkg::POS_W-1:0] event_z,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [sgt_pkg::LVL_W-1:0]        cfg_data
);
    import sgt_pkg::*;

    // commands from the sequencer to the datapath
    dp_cmd_t cmd;

    // sequencer: accept, square, root, commit
    sgt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: frame latch, distance unit, three detectors, result register
    sgt_datapath #(
        .CLAP_WINDOW  (CLAP_WINDOW),
        .RAISE_WINDOW (RAISE_WINDOW)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .confident_mask   (confident_mask),
        .right_hand_x     (right_hand_x),
        .right_hand_y     (right_hand_y),
        .right_hand_z     (right_hand_z),
        .left_hand_x      (left_hand_x),
        .left_hand_y      (left_hand_y),
        .left_hand_z      (left_hand_z),
        .right_shoulder_y (right_shoulder_y),
        .left_shoulder_y  (left_shoulder_y),
        .fired            (fired),
        .source           (source),
        .event_x          (event_x),
        .event_y          (event_y),
        .event_z          (event_z)
    );

endmodule
